// ===== src/psf_pkg.sv =====
// Shared types and constants for the pose smoothing filter.
// No dependencies; compiled first.
package psf_pkg;

    localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
    localparam logic [31:0] LERP_MARGIN = 32'd1024;
    localparam logic [15:0] GAIN_RESET  = 16'd328;

    // quaternion normalize: where the operand comes from and where it lands
    localparam logic [1:0] SRC_TQ   = 2'd0;
    localparam logic [1:0] SRC_HQ   = 2'd1;
    localparam logic [1:0] SRC_R    = 2'd2;
    localparam logic [1:0] DST_HELD = 2'd0;
    localparam logic [1:0] DST_CN   = 2'd1;
    localparam logic [1:0] DST_TN   = 2'd2;

    // divide / square root unit ops
    localparam logic OP_DIV  = 1'b0;
    localparam logic OP_SQRT = 1'b1;

    typedef struct packed {
        logic start;
        logic op;
    } psf_iter_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } psf_iter_sts_t;

    // round(atan(2^-i) * 2^30)
    function automatic logic [30:0] psf_atan(input logic [4:0] i);
        logic [30:0] a;
        case (i)
            5'd0:    a = 31'd843314857;
            5'd1:    a = 31'd497837829;
            5'd2:    a = 31'd263043837;
            5'd3:    a = 31'd133525159;
            5'd4:    a = 31'd67021687;
            5'd5:    a = 31'd33543516;
            5'd6:    a = 31'd16775851;
            5'd7:    a = 31'd8388437;
            5'd8:    a = 31'd4194283;
            5'd9:    a = 31'd2097149;
            5'd10:   a = 31'd1048576;
            5'd11:   a = 31'd524288;
            5'd12:   a = 31'd262144;
            5'd13:   a = 31'd131072;
            5'd14:   a = 31'd65536;
            5'd15:   a = 31'd32768;
            5'd16:   a = 31'd16384;
            5'd17:   a = 31'd8192;
            5'd18:   a = 31'd4096;
            5'd19:   a = 31'd2048;
            5'd20:   a = 31'd1024;
            5'd21:   a = 31'd512;
            5'd22:   a = 31'd256;
            5'd23:   a = 31'd128;
            5'd24:   a = 31'd64;
            5'd25:   a = 31'd32;
            5'd26:   a = 31'd16;
            5'd27:   a = 31'd8;
            5'd28:   a = 31'd4;
            5'd29:   a = 31'd2;
            5'd30:   a = 31'd1;
            default: a = 31'd0;
        endcase
        return a;
    endfunction

endpackage

// ===== src/psf_if.sv =====
// Valid/ready channel interfaces for target and smoothed pose words.
// No dependencies.
interface psf_target_if;
    logic        valid;
    logic        ready;
    logic        restart;
    logic [31:0] target_x;
    logic [31:0] target_y;
    logic [31:0] target_z;
    logic [31:0] target_qw;
    logic [31:0] target_qx;
    logic [31:0] target_qy;
    logic [31:0] target_qz;

    modport source (output valid, restart, target_x, target_y, target_z,
                    target_qw, target_qx, target_qy, target_qz, input ready);
    modport sink   (input valid, restart, target_x, target_y, target_z,
                    target_qw, target_qx, target_qy, target_qz, output ready);
endinterface

interface psf_smooth_if;
    logic        valid;
    logic        ready;
    logic [31:0] smooth_x;
    logic [31:0] smooth_y;
    logic [31:0] smooth_z;
    logic [31:0] smooth_qw;
    logic [31:0] smooth_qx;
    logic [31:0] smooth_qy;
    logic [31:0] smooth_qz;

    modport source (output valid, smooth_x, smooth_y, smooth_z,
                    smooth_qw, smooth_qx, smooth_qy, smooth_qz, input ready);
    modport sink   (input valid, smooth_x, smooth_y, smooth_z,
                    smooth_qw, smooth_qx, smooth_qy, smooth_qz, output ready);
endinterface

// ===== src/pose_smoothing_filter.sv =====
// Pose smoothing filter top level: sequencer, shared multiplier and CORDIC datapath.
// Depends on psf_pkg, psf_if (interfaces) and psf_iter.
//
// Usage:
//   target  : valid/ready input channel, one word per pose (restart flag,
//             Q15.16 position, Q1.30 quaternion of any length).
//   smooth  : valid/ready output channel, one word per accepted input word,
//             the filtered pose (Q15.16 position, unit Q1.30 quaternion).
//   cfg_wr_en / cfg_wr_data : writes the Q0.16 smoothing gain; write it only
//             while the block is idle.
// One word is processed at a time; target.ready is high only when idle.
// A start word (restart, or first after reset) takes one normalize pass. A
// filtered word takes three normalize passes, one square root, one divide
// and two CORDIC runs; on the linear-blend path it takes the three
// normalize passes alone. The shared divide/square-root unit retires one
// quotient or root bit per cycle, and each normalize needs one root and
// four divides.
// Results sit in an output register; the next word is accepted while the
// previous result waits, and the sequencer stalls at its end only if the
// receiver still has not taken the older one.
// Reset: gain returns to 328, no pose is held, output channel is empty.
module pose_smoothing_filter #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    psf_target_if.sink        target,
    psf_smooth_if.source      smooth,
    input  logic              cfg_wr_en,
    input  logic [15:0]       cfg_wr_data
);
    import psf_pkg::*;

    localparam int CW = $clog2(CORDIC_STEPS);

    // sequencer states
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_POS    = 5'd1;
    localparam logic [4:0] S_NORM2  = 5'd2;
    localparam logic [4:0] S_NLOAD  = 5'd3;
    localparam logic [4:0] S_NMAX   = 5'd4;
    localparam logic [4:0] S_NSHIFT = 5'd5;
    localparam logic [4:0] S_NSUMSQ = 5'd6;
    localparam logic [4:0] S_NSQGO  = 5'd7;
    localparam logic [4:0] S_NSQRT  = 5'd8;
    localparam logic [4:0] S_NDGO   = 5'd9;
    localparam logic [4:0] S_NDWAIT = 5'd10;
    localparam logic [4:0] S_DOT    = 5'd11;
    localparam logic [4:0] S_DOTFIN = 5'd12;
    localparam logic [4:0] S_DSQ    = 5'd13;
    localparam logic [4:0] S_SSQGO  = 5'd14;
    localparam logic [4:0] S_SSQRT  = 5'd15;
    localparam logic [4:0] S_VEC    = 5'd16;
    localparam logic [4:0] S_PHI    = 5'd17;
    localparam logic [4:0] S_ROT    = 5'd18;
    localparam logic [4:0] S_W1GO   = 5'd19;
    localparam logic [4:0] S_W1WAIT = 5'd20;
    localparam logic [4:0] S_W0MUL  = 5'd21;
    localparam logic [4:0] S_BLEND  = 5'd22;
    localparam logic [4:0] S_FIN    = 5'd23;

    localparam logic [63:0] MX_HI8 = 64'd1 << 38;
    localparam logic [63:0] MX_HI1 = 64'd1 << 30;
    localparam logic [63:0] MX_LO8 = 64'd1 << 21;
    localparam logic [63:0] MX_LO1 = 64'd1 << 29;

    function automatic logic signed [67:0] shr_rnd(input logic signed [67:0] v,
                                                    input int unsigned sh);
        logic [67:0] m;
        m = v[67] ? 68'(-v) : 68'(v);
        m = (m + (68'd1 << (sh - 1))) >> sh;
        return v[67] ? -$signed(m) : $signed(m);
    endfunction

    // control
    logic [4:0]     state_reg;
    logic [CW-1:0]  cnt_reg;
    logic           primed_reg;
    logic [15:0]    gain_reg;
    logic [1:0]     src_reg;
    logic [1:0]     dst_reg;
    logic [4:0]     ret_reg;
    logic           ov_reg;

    // pose state and captured word
    logic signed [31:0] tp_reg [3];
    logic signed [31:0] tq_reg [4];
    logic signed [31:0] hp_reg [3];
    logic signed [31:0] hq_reg [4];
    logic signed [31:0] op_reg [3];
    logic signed [31:0] oq_reg [4];

    // normalize working set
    logic [63:0]        nm_reg [4];
    logic [3:0]         nsg_reg;
    logic [63:0]        mx_reg;
    logic [31:0]        n_reg;

    // slerp working set
    logic signed [31:0] cn_reg [4];
    logic signed [31:0] tn_reg [4];
    logic signed [63:0] r_reg [4];
    logic signed [63:0] acc_reg;
    logic               flip_reg;
    logic [30:0]        d_reg;
    logic [30:0]        s_reg;
    logic signed [33:0] w0_reg;
    logic signed [33:0] w1_reg;
    logic signed [33:0] cx_reg;
    logic signed [33:0] cy_reg;
    logic signed [33:0] cz_reg;
    logic               cvec_reg;
    logic signed [67:0] mul_reg;

    // combinational
    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;
    logic [1:0]         idx;
    logic [1:0]         pidx;
    logic [1:0]         bidx;
    logic signed [67:0] pos_step;
    logic signed [67:0] w0_corr;
    logic signed [67:0] phi_full;
    logic signed [63:0] srcv [4];
    logic [4:0]         sh;
    logic signed [33:0] cdx;
    logic signed [33:0] cdy;
    logic signed [33:0] cat;
    logic               cup;
    logic [63:0]        dot_mag;
    logic [34:0]        dot_rnd;
    logic [30:0]        d_clamp;
    logic [33:0]        abs_s;
    logic signed [31:0] q32;

    psf_iter_ctl_t      ictl;
    psf_iter_sts_t      ists;
    logic [63:0]        inum;
    logic [31:0]        iden;
    logic [33:0]        ires;

    psf_iter u_iter (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ictl),
        .num    (inum),
        .den    (iden),
        .sts    (ists),
        .result (ires)
    );

    assign idx  = cnt_reg[1:0];
    assign pidx = cnt_reg[1:0] - 2'd1;
    // blend: component finished at even counts 2, 4, 6, 8
    assign bidx = cnt_reg[2:1] - 2'd1;
    assign q32  = $signed(ires[31:0]);

    assign pos_step = shr_rnd(mul_reg, 16);
    assign w0_corr  = shr_rnd(mul_reg, 30);
    assign phi_full = shr_rnd(mul_reg, 16);

    // normalize source select
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            case (src_reg)
                SRC_TQ:  srcv[i] = 64'(tq_reg[i]);
                SRC_HQ:  srcv[i] = 64'(hq_reg[i]);
                default: srcv[i] = r_reg[i];
            endcase
        end
    end

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_POS:
            begin
                mul_a = 34'(tp_reg[idx]) - 34'(hp_reg[idx]);
                mul_b = $signed({18'd0, gain_reg});
            end
            S_NSUMSQ:
            begin
                mul_a = $signed({4'd0, nm_reg[idx][29:0]});
                mul_b = $signed({4'd0, nm_reg[idx][29:0]});
            end
            S_DOT:
            begin
                mul_a = 34'(cn_reg[idx]);
                mul_b = 34'(tn_reg[idx]);
            end
            S_DSQ:
            begin
                mul_a = $signed({3'd0, d_reg});
                mul_b = $signed({3'd0, d_reg});
            end
            S_PHI:
            begin
                mul_a = cz_reg;
                mul_b = $signed({18'd0, gain_reg});
            end
            S_W0MUL:
            begin
                mul_a = $signed({3'd0, d_reg});
                mul_b = w1_reg;
            end
            S_BLEND:
            begin
                if (!cnt_reg[0])
                begin
                    mul_a = w0_reg;
                    mul_b = 34'(cn_reg[cnt_reg[2:1]]);
                end
                else
                begin
                    mul_a = w1_reg;
                    mul_b = flip_reg ? -34'(tn_reg[cnt_reg[2:1]])
                                     : 34'(tn_reg[cnt_reg[2:1]]);
                end
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // CORDIC step: vectoring drives y to zero, rotation drives z to zero
    assign sh  = 5'(cnt_reg);
    assign cdx = cy_reg >>> sh;
    assign cdy = cx_reg >>> sh;
    assign cat = $signed({3'd0, psf_atan(sh)});
    assign cup = cvec_reg ? ~cy_reg[33] : cz_reg[33];

    // dot product to cosine term
    assign dot_mag = acc_reg[63] ? 64'(-acc_reg) : 64'(acc_reg);
    assign dot_rnd = 35'((dot_mag + 64'd536870912) >> 30);
    assign d_clamp = (dot_rnd > 35'(ONE_Q30)) ? ONE_Q30[30:0] : dot_rnd[30:0];
    assign abs_s   = cy_reg[33] ? 34'(-cy_reg) : 34'(cy_reg);

    // divide / root unit requests
    always_comb
    begin
        ictl.start = 1'b0;
        ictl.op    = OP_DIV;
        inum       = '0;
        iden       = '0;
        case (state_reg)
            S_NSQGO:
            begin
                ictl.start = 1'b1;
                ictl.op    = OP_SQRT;
                inum       = acc_reg;
            end
            S_SSQGO:
            begin
                ictl.start = 1'b1;
                ictl.op    = OP_SQRT;
                inum       = acc_reg;
            end
            S_NDGO:
            begin
                ictl.start = 1'b1;
                inum       = {4'd0, nm_reg[idx][29:0], 30'd0} + {33'd0, n_reg[31:1]};
                iden       = n_reg;
            end
            S_W1GO:
            begin
                ictl.start = 1'b1;
                inum       = {abs_s[33:0], 30'd0} + {34'd0, s_reg[30:1]};
                iden       = {1'b0, s_reg};
            end
            default:
            begin
                ictl.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            primed_reg <= 1'b0;
            gain_reg   <= GAIN_RESET;
            src_reg    <= SRC_TQ;
            dst_reg    <= DST_HELD;
            ret_reg    <= S_IDLE;
            ov_reg     <= 1'b0;
            nsg_reg    <= '0;
            mx_reg     <= '0;
            n_reg      <= '0;
            acc_reg    <= '0;
            flip_reg   <= 1'b0;
            d_reg      <= '0;
            s_reg      <= '0;
            w0_reg     <= '0;
            w1_reg     <= '0;
            cx_reg     <= '0;
            cy_reg     <= '0;
            cz_reg     <= '0;
            cvec_reg   <= 1'b0;
            mul_reg    <= '0;
            for (int i = 0; i < 3; i++)
            begin
                tp_reg[i] <= '0;
                hp_reg[i] <= '0;
                op_reg[i] <= '0;
            end
            for (int i = 0; i < 4; i++)
            begin
                tq_reg[i] <= '0;
                hq_reg[i] <= (i == 0) ? $signed(ONE_Q30) : '0;
                oq_reg[i] <= '0;
                nm_reg[i] <= '0;
                cn_reg[i] <= '0;
                tn_reg[i] <= '0;
                r_reg[i]  <= '0;
            end
        end
        else
        begin
            mul_reg <= mul_a * mul_b;

            if (cfg_wr_en)
                gain_reg <= cfg_wr_data;

            // S_FIN reloads the output register itself
            if (ov_reg && smooth.ready && (state_reg != S_FIN))
                ov_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (target.valid)
                    begin
                        tp_reg[0] <= $signed(target.target_x);
                        tp_reg[1] <= $signed(target.target_y);
                        tp_reg[2] <= $signed(target.target_z);
                        tq_reg[0] <= $signed(target.target_qw);
                        tq_reg[1] <= $signed(target.target_qx);
                        tq_reg[2] <= $signed(target.target_qy);
                        tq_reg[3] <= $signed(target.target_qz);
                        cnt_reg   <= '0;
                        if (target.restart || !primed_reg)
                        begin
                            // start pose: store as is, normalize quaternion
                            hp_reg[0]  <= $signed(target.target_x);
                            hp_reg[1]  <= $signed(target.target_y);
                            hp_reg[2]  <= $signed(target.target_z);
                            primed_reg <= 1'b1;
                            src_reg    <= SRC_TQ;
                            dst_reg    <= DST_HELD;
                            ret_reg    <= S_FIN;
                            state_reg  <= S_NLOAD;
                        end
                        else
                        begin
                            state_reg <= S_POS;
                        end
                    end
                end

                // position EMA; the registered multiplier product updates the previous component
                S_POS:
                begin
                    if (cnt_reg != '0)
                        hp_reg[pidx] <= hp_reg[pidx] + pos_step[31:0];
                    if (cnt_reg == CW'(3))
                    begin
                        src_reg   <= SRC_TQ;
                        dst_reg   <= DST_TN;
                        ret_reg   <= S_NORM2;
                        state_reg <= S_NLOAD;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end

                S_NORM2:
                begin
                    src_reg   <= SRC_HQ;
                    dst_reg   <= DST_CN;
                    ret_reg   <= S_DOT;
                    state_reg <= S_NLOAD;
                end

                // ---- normalize subroutine ----
                S_NLOAD:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        nm_reg[i]  <= srcv[i][63] ? 64'(-srcv[i]) : 64'(srcv[i]);
                        nsg_reg[i] <= srcv[i][63];
                    end
                    mx_reg    <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_NMAX;
                end

                S_NMAX:
                begin
                    if (nm_reg[idx] > mx_reg)
                        mx_reg <= nm_reg[idx];
                    if (cnt_reg == CW'(3))
                        state_reg <= S_NSHIFT;
                    else
                        cnt_reg <= cnt_reg + CW'(1);
                end

                // bring the largest magnitude into [2^29, 2^30)
                S_NSHIFT:
                begin
                    cnt_reg <= '0;
                    acc_reg <= '0;
                    if (mx_reg == '0)
                    begin
                        // zero quaternion maps to identity
                        case (dst_reg)
                            DST_HELD:
                            begin
                                hq_reg[0] <= $signed(ONE_Q30);
                                for (int i = 1; i < 4; i++)
                                    hq_reg[i] <= '0;
                            end
                            DST_CN:
                            begin
                                cn_reg[0] <= $signed(ONE_Q30);
                                for (int i = 1; i < 4; i++)
                                    cn_reg[i] <= '0;
                            end
                            default:
                            begin
                                tn_reg[0] <= $signed(ONE_Q30);
                                for (int i = 1; i < 4; i++)
                                    tn_reg[i] <= '0;
                            end
                        endcase
                        state_reg <= ret_reg;
                    end
                    else if (mx_reg >= MX_HI8)
                    begin
                        mx_reg <= mx_reg >> 8;
                        for (int i = 0; i < 4; i++)
                            nm_reg[i] <= nm_reg[i] >> 8;
                    end
                    else if (mx_reg >= MX_HI1)
                    begin
                        mx_reg <= mx_reg >> 1;
                        for (int i = 0; i < 4; i++)
                            nm_reg[i] <= nm_reg[i] >> 1;
                    end
                    else if (mx_reg < MX_LO8)
                    begin
                        mx_reg <= mx_reg << 8;
                        for (int i = 0; i < 4; i++)
                            nm_reg[i] <= nm_reg[i] << 8;
                    end
                    else if (mx_reg < MX_LO1)
                    begin
                        mx_reg <= mx_reg << 1;
                        for (int i = 0; i < 4; i++)
                            nm_reg[i] <= nm_reg[i] << 1;
                    end
                    else
                    begin
                        state_reg <= S_NSUMSQ;
                    end
                end

                S_NSUMSQ:
                begin
                    if (cnt_reg != '0)
                        acc_reg <= acc_reg + mul_reg[63:0];
                    if (cnt_reg == CW'(4))
                        state_reg <= S_NSQGO;
                    else
                        cnt_reg <= cnt_reg + CW'(1);
                end

                S_NSQGO:
                begin
                    state_reg <= S_NSQRT;
                end

                S_NSQRT:
                begin
                    if (ists.done)
                    begin
                        n_reg     <= ires[31:0];
                        cnt_reg   <= '0;
                        state_reg <= S_NDGO;
                    end
                end

                S_NDGO:
                begin
                    state_reg <= S_NDWAIT;
                end

                S_NDWAIT:
                begin
                    if (ists.done)
                    begin
                        case (dst_reg)
                            DST_HELD: hq_reg[idx] <= nsg_reg[idx] ? -q32 : q32;
                            DST_CN:   cn_reg[idx] <= nsg_reg[idx] ? -q32 : q32;
                            default:  tn_reg[idx] <= nsg_reg[idx] ? -q32 : q32;
                        endcase
                        if (cnt_reg == CW'(3))
                        begin
                            acc_reg   <= '0;
                            cnt_reg   <= '0;
                            state_reg <= ret_reg;
                        end
                        else
                        begin
                            cnt_reg   <= cnt_reg + CW'(1);
                            state_reg <= S_NDGO;
                        end
                    end
                end

                // ---- orientation ----
                S_DOT:
                begin
                    if (cnt_reg != '0)
                        acc_reg <= acc_reg + mul_reg[63:0];
                    if (cnt_reg == CW'(4))
                        state_reg <= S_DOTFIN;
                    else
                        cnt_reg <= cnt_reg + CW'(1);
                end

                // take the short arc; near-parallel falls back to a linear blend
                S_DOTFIN:
                begin
                    flip_reg <= acc_reg[63];
                    d_reg    <= d_clamp;
                    cnt_reg  <= '0;
                    if ({1'b0, d_clamp} >= ONE_Q30 - LERP_MARGIN)
                    begin
                        w0_reg    <= 34'sd65536 - $signed({18'd0, gain_reg});
                        w1_reg    <= $signed({18'd0, gain_reg});
                        state_reg <= S_BLEND;
                    end
                    else
                    begin
                        state_reg <= S_DSQ;
                    end
                end

                S_DSQ:
                begin
                    if (cnt_reg == CW'(1))
                    begin
                        acc_reg   <= 64'sh1000_0000_0000_0000 - mul_reg[63:0];
                        state_reg <= S_SSQGO;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end

                S_SSQGO:
                begin
                    state_reg <= S_SSQRT;
                end

                S_SSQRT:
                begin
                    if (ists.done)
                    begin
                        s_reg     <= ires[30:0];
                        cx_reg    <= $signed({3'd0, d_reg});
                        cy_reg    <= $signed({3'd0, ires[30:0]});
                        cz_reg    <= '0;
                        cvec_reg  <= 1'b1;
                        cnt_reg   <= '0;
                        state_reg <= S_VEC;
                    end
                end

                S_VEC, S_ROT:
                begin
                    cx_reg <= cup ? cx_reg + cdx : cx_reg - cdx;
                    cy_reg <= cup ? cy_reg - cdy : cy_reg + cdy;
                    cz_reg <= cup ? cz_reg + cat : cz_reg - cat;
                    if (cnt_reg == CW'(CORDIC_STEPS - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= (state_reg == S_VEC) ? S_PHI : S_W1GO;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end

                // step angle = theta * g, then rotate the unit vector by it
                S_PHI:
                begin
                    if (cnt_reg == CW'(1))
                    begin
                        cz_reg    <= phi_full[33:0];
                        cx_reg    <= $signed({2'd0, ONE_Q30});
                        cy_reg    <= '0;
                        cvec_reg  <= 1'b0;
                        cnt_reg   <= '0;
                        state_reg <= S_ROT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end

                S_W1GO:
                begin
                    state_reg <= S_W1WAIT;
                end

                S_W1WAIT:
                begin
                    if (ists.done)
                    begin
                        w1_reg    <= cy_reg[33] ? -$signed(ires) : $signed(ires);
                        cnt_reg   <= '0;
                        state_reg <= S_W0MUL;
                    end
                end

                S_W0MUL:
                begin
                    if (cnt_reg == CW'(1))
                    begin
                        w0_reg    <= cx_reg - w0_corr[33:0];
                        cnt_reg   <= '0;
                        state_reg <= S_BLEND;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end

                // r = w0*c + w1*t, two products per component
                S_BLEND:
                begin
                    if (cnt_reg != '0)
                    begin
                        if (cnt_reg[0])
                            acc_reg <= mul_reg[63:0];
                        else
                            r_reg[bidx] <= acc_reg + mul_reg[63:0];
                    end
                    if (cnt_reg == CW'(8))
                    begin
                        src_reg   <= SRC_R;
                        dst_reg   <= DST_HELD;
                        ret_reg   <= S_FIN;
                        state_reg <= S_NLOAD;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end

                S_FIN:
                begin
                    if (!ov_reg || smooth.ready)
                    begin
                        for (int i = 0; i < 3; i++)
                            op_reg[i] <= hp_reg[i];
                        for (int i = 0; i < 4; i++)
                            oq_reg[i] <= hq_reg[i];
                        ov_reg    <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign target.ready    = (state_reg == S_IDLE);
    assign smooth.valid    = ov_reg;
    assign smooth.smooth_x  = op_reg[0];
    assign smooth.smooth_y  = op_reg[1];
    assign smooth.smooth_z  = op_reg[2];
    assign smooth.smooth_qw = oq_reg[0];
    assign smooth.smooth_qx = oq_reg[1];
    assign smooth.smooth_qy = oq_reg[2];
    assign smooth.smooth_qz = oq_reg[3];

endmodule

// ===== src/psf_iter.sv =====
// One-bit-per-cycle unsigned divider and integer square root, one shared subtractor.
// Depends on psf_pkg.
module psf_iter (
    input  logic                  clk,
    input  logic                  rst_n,
    input  psf_pkg::psf_iter_ctl_t ctl,
    input  logic [63:0]           num,
    input  logic [31:0]           den,
    output psf_pkg::psf_iter_sts_t sts,
    output logic [33:0]           result
);
    import psf_pkg::*;

    // divide: quotient assumed below 2^34, i.e. num >> 34 < den
    localparam int DIV_STEPS  = 34;
    localparam int SQRT_STEPS = 32;

    logic        run_reg;
    logic        done_reg;
    logic        op_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] acc_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;

    logic [63:0] lhs;
    logic [63:0] rhs;
    logic [64:0] diff;
    logic        ge;

    always_comb
    begin
        if (op_reg == OP_SQRT)
        begin
            lhs = acc_reg;
            rhs = res_reg + bit_reg;
        end
        else
        begin
            lhs = {31'd0, acc_reg[31:0], res_reg[33]};
            rhs = {32'd0, bit_reg[31:0]};
        end
        diff = {1'b0, lhs} - {1'b0, rhs};
        ge   = ~diff[64];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_DIV;
            cnt_reg  <= '0;
            acc_reg  <= '0;
            res_reg  <= '0;
            bit_reg  <= '0;
        end
        else if (ctl.start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            op_reg   <= ctl.op;
            if (ctl.op == OP_SQRT)
            begin
                acc_reg <= num;
                res_reg <= '0;
                bit_reg <= 64'd1 << 62;
                cnt_reg <= 6'(SQRT_STEPS - 1);
            end
            else
            begin
                acc_reg <= {34'd0, num[63:34]};
                res_reg <= {30'd0, num[33:0]};
                bit_reg <= {32'd0, den};
                cnt_reg <= 6'(DIV_STEPS - 1);
            end
        end
        else if (run_reg)
        begin
            if (op_reg == OP_SQRT)
            begin
                if (ge)
                begin
                    acc_reg <= diff[63:0];
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            else
            begin
                acc_reg <= ge ? diff[63:0] : lhs;
                res_reg <= {30'd0, res_reg[32:0], ge};
            end
            if (cnt_reg == 6'd0)
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg  <= cnt_reg - 6'd1;
                done_reg <= 1'b0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign sts.busy = run_reg;
    assign sts.done = done_reg;
    assign result   = res_reg[33:0];

endmodule

// ===== src/psf_checker.sv =====
// Port-level assertions for the pose smoothing filter, bound to the top level.
// Depends on pose_smoothing_filter and psf_if.
module psf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        tgt_valid,
    input logic        tgt_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_x,
    input logic [31:0] out_qw
);

    // one word in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        tgt_valid && tgt_ready |=> !tgt_ready)
        else $error("input accepted while previous word still in work");

    // a result appears only at the end of a busy period
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!tgt_ready))
        else $error("result appeared without work in progress");

    a_out_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    a_out_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_x) && $stable(out_qw))
        else $error("output word changed while stalled");

endmodule

bind pose_smoothing_filter psf_checker u_psf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .tgt_valid (target.valid),
    .tgt_ready (target.ready),
    .out_valid (smooth.valid),
    .out_ready (smooth.ready),
    .out_x     (smooth.smooth_x),
    .out_qw    (smooth.smooth_qw)
);
